// ===== sv/vpgcm_pkg.sv =====
package vpgcm_pkg;

   localparam int GROUPS_DEF           = 6;
   localparam int PLANES_PER_GROUP_DEF = 6;
   localparam int FRAC_BITS_DEF        = 16;

   localparam int COEF_W          = 32;
   localparam int COEFS_PER_PLANE = 4;
   localparam int INDEX_W         = 8;
   localparam int MASK_W          = 8;
   localparam int MASK_REGS       = 6;
   localparam int MASK_IDX_W      = 3;
   localparam int CSR_IDX_W       = 3;
   localparam int PROD_W          = 2 * COEF_W;
   localparam int SUM_W           = PROD_W + 3;

   localparam logic signed [COEF_W-1:0] SCALE_RESET = 32'sd65536;

   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_CLASSIFY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SCALE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_F = 3'd6;

   function automatic logic signed [PROD_W-1:0] mul_s(input logic signed [COEF_W-1:0] a,
                                                      input logic signed [COEF_W-1:0] b);
      mul_s = PROD_W'(a) * PROD_W'(b);
   endfunction

endpackage

// ===== sv/vpgcm_ram.sv =====
module vpgcm_ram
   import vpgcm_pkg::*;
#(
   parameter int WIDTH = 128,
   parameter int DEPTH = 36,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_en,
   input  logic [AW-1:0]    write_addr,
   input  logic [WIDTH-1:0] write_data,
   input  logic [AW-1:0]    read_addr,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== sv/vertex_plane_group_cull_mask.sv =====
// a classify beat reads one plane row from the coefficient ram per cycle through the ram read
// register, product and partial-sum registers; the result is raised once these have drained
// and the output is free, and the next beat can be taken in the cycle the result is raised.
// a load beat reads its ram row, then writes it back; coefficients are undefined until written.
// throughput is set by the single read port of the coefficient ram, one plane per cycle.
// reset clears control state and the mask registers and presets scale to SCALE_RESET.
module vertex_plane_group_cull_mask
   import vpgcm_pkg::*;
#(
   parameter int GROUPS           = GROUPS_DEF,
   parameter int PLANES_PER_GROUP = PLANES_PER_GROUP_DEF,
   parameter int FRAC_BITS        = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic signed [COEF_W-1:0] req_coord_x,
   input  logic signed [COEF_W-1:0] req_coord_y,
   input  logic signed [COEF_W-1:0] req_coord_z,
   input  logic signed [COEF_W-1:0] req_coord_w,
   input  logic [INDEX_W-1:0]       req_coef_index,
   input  logic signed [COEF_W-1:0] req_coef_value,
   input  logic                     req_last,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [MASK_W-1:0]        rsp_cull_mask,
   output logic                     rsp_last_out,

   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_wdata
);

   localparam int ROWS  = GROUPS * PLANES_PER_GROUP;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W = $clog2(ROWS + 1);
   localparam int GRP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PLN_W = (PLANES_PER_GROUP > 1) ? $clog2(PLANES_PER_GROUP) : 1;
   localparam int ROW_BITS = COEF_W * COEFS_PER_PLANE;
   localparam int DEPTH = ROWS * COEFS_PER_PLANE;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD_WR,
      ST_RUN
   } state_type;

   // control
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          plane_cnt_ff, plane_cnt_in;
   logic [GRP_W-1:0]          grp_cnt_ff, grp_cnt_in;
   logic [PLN_W-1:0]          pln_cnt_ff, pln_cnt_in;
   logic                      v1_ff, v1_in;
   logic                      v2_ff;
   logic                      v3_ff;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload
   logic [MASK_W-1:0]         acc_mask_ff, acc_mask_in;
   logic [MASK_W-1:0]         rsp_mask_ff, rsp_mask_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      last_ff, last_in;
   logic signed [COEF_W-1:0]  x_ff, y_ff, z_ff, w_ff;
   logic [ROW_W-1:0]          load_row_ff, load_row_in;
   logic [1:0]                load_sel_ff, load_sel_in;
   logic signed [COEF_W-1:0]  load_val_ff, load_val_in;
   logic [GRP_W-1:0]          g1_ff, g1_in, g2_ff, g3_ff;
   logic signed [PROD_W-1:0]  prod_ff [COEFS_PER_PLANE];
   logic signed [SUM_W-1:0]   s0_ff, s1_ff;

   // registers
   logic signed [COEF_W-1:0]  scale_ff;
   logic [MASK_W-1:0]         mask_reg_ff [MASK_REGS];

   // ram
   logic                      ram_we;
   logic [ROW_W-1:0]          ram_raddr;
   logic [ROW_BITS-1:0]       ram_rdata;
   logic [ROW_BITS-1:0]       ram_wdata;

   logic                      req_take;
   logic                      rsp_free;
   logic                      load_ok;
   logic signed [SUM_W-1:0]   w_wide;
   logic signed [SUM_W-1:0]   total;
   logic                      reject;
   logic [MASK_IDX_W-1:0]     g_ext;
   logic [MASK_W-1:0]         grp_mask;

   vpgcm_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(ROWS)
   ) u_coef_ram (
      .clock     (clock),
      .write_en  (ram_we),
      .write_addr(load_row_ff),
      .write_data(ram_wdata),
      .read_addr (ram_raddr),
      .read_data (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign load_ok   = ({1'b0, req_coef_index} < (INDEX_W + 1)'(DEPTH));
   assign ram_we    = (state_ff == ST_LOAD_WR);

   always_comb begin
      ram_wdata = ram_rdata;
      ram_wdata[load_sel_ff * COEF_W +: COEF_W] = load_val_ff;
   end

   // plane sum and compare
   assign w_wide = {{(SUM_W - COEF_W){w_ff[COEF_W-1]}}, w_ff} <<< FRAC_BITS;
   assign total  = s0_ff + s1_ff;
   assign reject = !total[SUM_W-1] && (total != '0);
   assign g_ext  = MASK_IDX_W'(g3_ff);
   assign grp_mask = (g_ext < MASK_IDX_W'(MASK_REGS)) ? mask_reg_ff[g_ext] : '0;

   always_comb begin
      state_in     = state_ff;
      plane_cnt_in = plane_cnt_ff;
      grp_cnt_in   = grp_cnt_ff;
      pln_cnt_in   = pln_cnt_ff;
      v1_in        = 1'b0;
      g1_in        = grp_cnt_ff;
      acc_mask_in  = acc_mask_ff;
      last_in      = last_ff;
      load_row_in  = load_row_ff;
      load_sel_in  = load_sel_ff;
      load_val_in  = load_val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mask_in  = rsp_mask_ff;
      rsp_last_in  = rsp_last_ff;
      ram_raddr    = plane_cnt_ff[ROW_W-1:0];

      if (v3_ff && reject) begin
         acc_mask_in = acc_mask_ff | grp_mask;
      end

      case (state_ff)
         ST_IDLE: begin
            ram_raddr = ROW_W'(req_coef_index[INDEX_W-1:2]);
            if (req_take) begin
               if (req_mode == MODE_CLASSIFY) begin
                  state_in     = ST_RUN;
                  plane_cnt_in = '0;
                  grp_cnt_in   = '0;
                  pln_cnt_in   = '0;
                  acc_mask_in  = '0;
                  last_in      = req_last;
               end else if (load_ok) begin
                  state_in    = ST_LOAD_WR;
                  load_row_in = ROW_W'(req_coef_index[INDEX_W-1:2]);
                  load_sel_in = req_coef_index[1:0];
                  load_val_in = req_coef_value;
               end
            end
         end
         ST_LOAD_WR: begin
            state_in = ST_IDLE;
         end
         ST_RUN: begin
            if (plane_cnt_ff < CNT_W'(ROWS)) begin
               v1_in        = 1'b1;
               plane_cnt_in = plane_cnt_ff + 1'b1;
               if (pln_cnt_ff == PLN_W'(PLANES_PER_GROUP - 1)) begin
                  pln_cnt_in = '0;
                  grp_cnt_in = grp_cnt_ff + 1'b1;
               end else begin
                  pln_cnt_in = pln_cnt_ff + 1'b1;
               end
            end else if (!v1_ff && !v2_ff && !v3_ff && rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_mask_in  = acc_mask_ff;
               rsp_last_in  = last_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plane_cnt_ff <= '0;
         grp_cnt_ff   <= '0;
         pln_cnt_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plane_cnt_ff <= plane_cnt_in;
         grp_cnt_ff   <= grp_cnt_in;
         pln_cnt_ff   <= pln_cnt_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_mask_ff <= acc_mask_in;
      last_ff     <= last_in;
      load_row_ff <= load_row_in;
      load_sel_ff <= load_sel_in;
      load_val_ff <= load_val_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_last_ff <= rsp_last_in;
   end

   // vertex capture and plane pipeline
   always_ff @(posedge clock) begin
      if (req_take && req_mode == MODE_CLASSIFY) begin
         x_ff <= req_coord_x;
         y_ff <= req_coord_y;
         z_ff <= req_coord_z;
         w_ff <= req_coord_w;
      end
      g1_ff <= g1_in;
      g2_ff <= g1_ff;
      g3_ff <= g2_ff;
      prod_ff[0] <= mul_s(ram_rdata[0 * COEF_W +: COEF_W], x_ff);
      prod_ff[1] <= mul_s(ram_rdata[1 * COEF_W +: COEF_W], y_ff);
      prod_ff[2] <= mul_s(ram_rdata[2 * COEF_W +: COEF_W], z_ff);
      prod_ff[3] <= mul_s(ram_rdata[3 * COEF_W +: COEF_W], scale_ff);
      s0_ff <= SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]);
      s1_ff <= SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]) - w_wide;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         for (int i = 0; i < MASK_REGS; i++) begin
            mask_reg_ff[i] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index == REG_SCALE) begin
            scale_ff <= csr_wdata;
         end else if (csr_index >= REG_MASK_A && csr_index <= REG_MASK_F) begin
            mask_reg_ff[MASK_IDX_W'(csr_index - REG_MASK_A)] <= csr_wdata[MASK_W-1:0];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cull_mask = rsp_mask_ff;
   assign rsp_last_out  = rsp_last_ff;

   a_pipe_only_in_run: assert property (@(posedge clock) disable iff (reset)
      (v1_ff || v2_ff || v3_ff) |-> state_ff == ST_RUN)
      else $error("plane pipeline active outside classify");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      plane_cnt_ff <= CNT_W'(ROWS))
      else $error("plane counter past last row");

   a_write_after_load: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> $past(req_take && req_mode == MODE_LOAD))
      else $error("coefficient write without load beat");

   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN && !v3_ff))
      else $error("result raised before pipeline drained");

endmodule

// ===== verif/tb_vertex_plane_group_cull_mask.sv =====
`timescale 1ns / 1ps

module tb_vertex_plane_group_cull_mask;
   import vpgcm_pkg::*;

   localparam int GROUPS           = GROUPS_DEF;
   localparam int PLANES_PER_GROUP = PLANES_PER_GROUP_DEF;
   localparam int FRAC_BITS        = FRAC_BITS_DEF;
   localparam int GROUP_STRIDE     = PLANES_PER_GROUP * COEFS_PER_PLANE;
   localparam int COEF_DEPTH       = GROUPS * GROUP_STRIDE;
   localparam int INDEX_MAX        = (1 << INDEX_W) - 1;
   localparam int COEF_A           = 0;
   localparam int COEF_D           = 3;
   localparam int ACC_W            = 2 * COEF_W + 4;
   localparam int LATENCY          = GROUPS * PLANES_PER_GROUP + 5;
   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 9;
   localparam int HOLD_CYCLES      = 600;
   localparam int CYCLE_LIMIT      = 1500000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam logic signed [COEF_W-1:0] Q_ONE = 1 << FRAC_BITS;

   typedef enum int {MAG_TINY, MAG_SMALL, MAG_MID, MAG_FULL, MAG_EDGE} mag_type;
   typedef enum int {MASKS_ONEHOT, MASKS_ALL, MASKS_NONE, MASKS_RANDOM} mask_set_type;

   typedef struct {
      logic                     mode;
      logic signed [COEF_W-1:0] x;
      logic signed [COEF_W-1:0] y;
      logic signed [COEF_W-1:0] z;
      logic signed [COEF_W-1:0] w;
      logic [INDEX_W-1:0]       index;
      logic signed [COEF_W-1:0] value;
      logic                     last;
   } req_beat_type;

   typedef struct {
      logic [MASK_W-1:0] mask;
      logic              last;
   } cull_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_mode = MODE_LOAD;
   logic signed [COEF_W-1:0] req_coord_x = '0;
   logic signed [COEF_W-1:0] req_coord_y = '0;
   logic signed [COEF_W-1:0] req_coord_z = '0;
   logic signed [COEF_W-1:0] req_coord_w = '0;
   logic [INDEX_W-1:0]       req_coef_index = '0;
   logic signed [COEF_W-1:0] req_coef_value = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [MASK_W-1:0]        rsp_cull_mask;
   logic                     rsp_last_out;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [COEF_W-1:0]        csr_wdata = '0;

   logic signed [COEF_W-1:0] plane_coef [COEF_DEPTH];
   logic signed [COEF_W-1:0] scale_q = SCALE_RESET;
   logic [MASK_W-1:0]        group_mask [MASK_REGS] = '{default: '0};

   req_beat_type    beat_q [$];
   cull_result_type cull_q [$];

   bit req_fire = 1'b0;
   bit hold_off = 1'b0;
   bit pressure_go = 1'b0;
   int src_gap_pct = 0;
   int snk_stall_pct = 0;
   int src_idle = 0;
   int snk_idle = 0;
   int mismatches = 0;
   int cycle_count = 0;

   vertex_plane_group_cull_mask #(
      .GROUPS           (GROUPS),
      .PLANES_PER_GROUP (PLANES_PER_GROUP),
      .FRAC_BITS        (FRAC_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_coord_w    (req_coord_w),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cull_mask  (rsp_cull_mask),
      .rsp_last_out   (rsp_last_out),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // exact plane sums, w lifted to the product's fraction bits
   function automatic logic [MASK_W-1:0] cull_for_vertex(input logic signed [COEF_W-1:0] x, y,
                                                         z, w);
      logic signed [ACC_W-1:0] plane_sum;
      logic [MASK_W-1:0]       mask;
      bit                      hit;
      int                      base;
      mask = '0;
      for (int g = 0; g < GROUPS; g++) begin
         hit = 1'b0;
         for (int p = 0; p < PLANES_PER_GROUP; p++) begin
            base = g * GROUP_STRIDE + p * COEFS_PER_PLANE;
            plane_sum = plane_coef[base] * x + plane_coef[base + 1] * y
                      + plane_coef[base + 2] * z + plane_coef[base + 3] * scale_q
                      - (w <<< FRAC_BITS);
            if (plane_sum > 0) hit = 1'b1;
         end
         if (hit && g < MASK_REGS) mask |= group_mask[g];
      end
      return mask;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 92) return $urandom_range(4, 10);
      else return $urandom_range(20, 80);
   endfunction

   function automatic mag_type rand_mag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return MAG_TINY;
      else if (r < 55) return MAG_SMALL;
      else if (r < 75) return MAG_MID;
      else if (r < 92) return MAG_FULL;
      else return MAG_EDGE;
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_q(input mag_type m);
      case (m)
         MAG_TINY:  return int'($urandom_range(0, 8192)) - 4096;
         MAG_SMALL: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
         MAG_MID:   return int'($urandom_range(0, 1 << 25)) - (1 << 24);
         MAG_FULL:  return $urandom;
         default: begin
            case ($urandom_range(0, 5))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return '0;
               3:       return -1;
               4:       return Q_ONE;
               default: return -Q_ONE;
            endcase
         end
      endcase
   endfunction

   task automatic push_load(input int idx, input logic signed [COEF_W-1:0] val);
      req_beat_type b;
      b.mode  = MODE_LOAD;
      b.x     = $urandom;
      b.y     = $urandom;
      b.z     = $urandom;
      b.w     = $urandom;
      b.index = INDEX_W'(idx);
      b.value = val;
      b.last  = 1'($urandom_range(0, 1));
      beat_q.push_back(b);
   endtask

   task automatic push_vertex(input logic signed [COEF_W-1:0] x, y, z, w, input logic last);
      req_beat_type b;
      b.mode  = MODE_CLASSIFY;
      b.x     = x;
      b.y     = y;
      b.z     = z;
      b.w     = w;
      b.index = INDEX_W'($urandom);
      b.value = $urandom;
      b.last  = last;
      beat_q.push_back(b);
   endtask

   task automatic load_group(input int g, input mag_type m);
      for (int k = 0; k < GROUP_STRIDE; k++)
         push_load(g * GROUP_STRIDE + k,
                   ($urandom_range(0, 9) == 0) ? rand_q(rand_mag()) : rand_q(m));
   endtask

   task automatic gen_random(input int n);
      int      made;
      int      r;
      int      len;
      mag_type m;
      made = 0;
      while (made < n) begin
         r = $urandom_range(0, 99);
         if (r < 7) begin
            load_group($urandom_range(0, GROUPS - 1), rand_mag());
            made += GROUP_STRIDE;
         end else if (r < 20) begin
            push_load($urandom_range(0, COEF_DEPTH - 1), rand_q(rand_mag()));
            made++;
         end else if (r < 25) begin
            push_load($urandom_range(COEF_DEPTH, INDEX_MAX), $urandom);
         end else begin
            len = $urandom_range(1, 8);
            m = rand_mag();
            for (int i = 0; i < len; i++)
               push_vertex(rand_q(m), rand_q(m), rand_q(m), rand_q(rand_mag()),
                           (i == len - 1) ^ ($urandom_range(0, 9) == 0));
            made += len;
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == REG_SCALE) scale_q = data;
      else if (idx <= REG_MASK_F) group_mask[idx - REG_MASK_A] = data[MASK_W-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input logic [COEF_W-1:0] scale, input mask_set_type style);
      logic [MASK_W-1:0] m;
      write_reg(REG_SCALE, scale);
      for (int g = 0; g < MASK_REGS; g++) begin
         case (style)
            MASKS_ONEHOT: m = MASK_W'(1) << g;
            MASKS_ALL:    m = '1;
            MASKS_NONE:   m = '0;
            default:      m = MASK_W'($urandom);
         endcase
         write_reg(CSR_IDX_W'(REG_MASK_A + g), COEF_W'(m));
      end
      write_reg(REG_SPARE, $urandom);
   endtask

   // idle means nothing queued, nothing offered, nothing owed, then a grace period
   task automatic wait_idle();
      @(negedge clock);
      while (beat_q.size() != 0 || req_valid || cull_q.size() != 0) @(negedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   task automatic run_phase(input logic [COEF_W-1:0] scale, input mask_set_type style,
                            input int n, input int src_pct, input int snk_pct,
                            input bit pressure);
      wait_idle();
      configure(scale, style);
      @(posedge clock);
      src_gap_pct = src_pct;
      snk_stall_pct = snk_pct;
      gen_random(n);
      if (pressure) pressure_go = 1'b1;
   endtask

   always @(negedge clock) begin : source
      req_beat_type b;
      if (!reset && (!req_valid || req_fire)) begin
         if (src_idle != 0) begin
            src_idle--;
            req_valid <= 1'b0;
         end else if (beat_q.size() != 0) begin
            b = beat_q.pop_front();
            req_mode       <= b.mode;
            req_coord_x    <= b.x;
            req_coord_y    <= b.y;
            req_coord_z    <= b.z;
            req_coord_w    <= b.w;
            req_coef_index <= b.index;
            req_coef_value <= b.value;
            req_last       <= b.last;
            req_valid      <= 1'b1;
            if ($urandom_range(0, 99) < src_gap_pct) src_idle = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : sink
      if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (snk_idle != 0) begin
         snk_idle--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < snk_stall_pct) begin
         snk_idle = idle_len();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin : monitor
      cull_result_type e;
      req_fire = !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cull_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: mask %02h last %0d",
                        rsp_cull_mask, rsp_last_out);
         end else begin
            e = cull_q.pop_front();
            if (rsp_cull_mask !== e.mask || rsp_last_out !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected mask %02h last %0d, got mask %02h last %0d",
                           e.mask, e.last, rsp_cull_mask, rsp_last_out);
            end
         end
      end
      if (req_fire) begin
         if (req_mode == MODE_LOAD) begin
            if (req_coef_index < COEF_DEPTH) plane_coef[req_coef_index] = req_coef_value;
         end else begin
            e.mask = cull_for_vertex(req_coord_x, req_coord_y, req_coord_z, req_coord_w);
            e.last = req_last;
            cull_q.push_back(e);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      src_gap_pct = 20;
      snk_stall_pct = 20;

      // group 0 plane 0 is w = x, the rest of group 0 are zero planes
      for (int k = 0; k < GROUP_STRIDE; k++)
         push_load(k, (k == COEF_A) ? Q_ONE : '0);
      for (int g = 1; g < GROUPS; g++)
         load_group(g, rand_mag());
      repeat (4) push_vertex(rand_q(MAG_FULL), rand_q(MAG_FULL), rand_q(MAG_FULL),
                             rand_q(MAG_FULL), 1'($urandom_range(0, 1)));

      wait_idle();
      configure(Q_ONE, MASKS_ONEHOT);
      @(posedge clock);
      push_vertex(32'sh0003_E800, 0, 0, 32'sh0003_E800, 1'b0);
      push_vertex(32'sh0003_E801, 0, 0, 32'sh0003_E800, 1'b0);
      push_vertex(-32'sh0001_3880, 0, 0, -32'sh0001_3880, 1'b1);
      push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      push_vertex(0, 0, 0, 32'h8000_0000, 1'b0);
      push_load(COEF_DEPTH, -1);
      push_load(INDEX_MAX, 32'h7FFF_FFFF);
      push_load(COEF_A, 32'h8000_0000);
      push_vertex(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 1'b1);
      push_load(COEF_D, 32'h7FFF_FFFF);
      push_vertex(0, 0, 0, 0, 1'b0);
      push_load(COEF_DEPTH - 1, 0);
      push_vertex(0, 0, 0, 0, 1'b1);
      push_load(COEF_A, Q_ONE);
      push_load(COEF_D, 0);
      push_vertex(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1'b1);

      run_phase(32'h7FFF_FFFF, MASKS_ALL, 200, 0, 0, 1'b0);
      run_phase(32'h8000_0000, MASKS_ONEHOT, 200, 40, 10, 1'b0);
      run_phase('0, MASKS_RANDOM, 200, 10, 40, 1'b0);
      run_phase($urandom, MASKS_RANDOM, 200, 30, 30, 1'b0);
      run_phase(Q_ONE, MASKS_RANDOM, 200, 0, 20, 1'b1);
      run_phase(rand_q(MAG_SMALL), MASKS_NONE, 100, 20, 20, 1'b0);

      wait_idle();
      if (mismatches == 0 && cull_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
